// File: hdl/assert_macros.svh
// Assertion helper macros for the timer wheel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion with asynchronous reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication form.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`endif

// File: hdl/htw_pkg.sv
// ---------------------------------------------------------------------------
// htw_pkg
// Types and constants shared by the hierarchical timer wheel.
// ---------------------------------------------------------------------------
`default_nettype none
package htw_pkg;
	localparam int TimerCount  = 32;
	localparam int WheelLevels = 4;
	localparam int LevelBits   = 8;
	localparam int IdW         = 5;
	localparam int MaxResults  = 32;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_TICK   = 2'd0;
	localparam func_t FUNC_ARM    = 2'd1;
	localparam func_t FUNC_CANCEL = 2'd2;
	localparam func_t FUNC_SKIP   = 2'd3;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_IDLE    = 2'd0;
	localparam stat_t ST_PENDING = 2'd1;
	localparam stat_t ST_WHEEL   = 2'd2;

	typedef struct packed {
		logic [31:0] expire;
		logic [9:0]  bidx;
		stat_t       stat;
		logic        fresh;
		logic        periodic;
		logic [30:0] interval;
	} slot_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [4:0]  timer_id;
		logic [30:0] amount;
		logic        repeat_req;
		logic [30:0] period;
	} in_t;

	typedef struct packed {
		logic [4:0] fired_id;
		logic       late;
		logic       last;
	} out_t;
endpackage
`default_nettype wire

// File: hdl/htw_if.sv
// ---------------------------------------------------------------------------
// htw_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
`default_nettype none
interface htw_in_if;
	logic valid;
	logic ready;
	htw_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface htw_out_if;
	logic valid;
	logic ready;
	htw_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/htw_ram.sv
// ---------------------------------------------------------------------------
// htw_ram
// Generic single-port RAM, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module htw_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// File: hdl/htw_slot_unit.sv
// ---------------------------------------------------------------------------
// htw_slot_unit
// Shared per-slot update: one timer slot examined per call.
// ---------------------------------------------------------------------------
`default_nettype none
module htw_slot_unit (
	input  wire logic [1:0]        func,
	input  wire logic [31:0]       clk_now,
	input  wire logic [30:0]       amount,
	input  wire logic [3:0]        rel,
	input  wire logic [31:0]       ridx,
	input  wire logic              full,
	input  wire htw_pkg::slot_t    sin,
	output htw_pkg::slot_t         sout,
	output logic                   fire,
	output logic                   late
);
	logic [31:0] rem;
	logic        cand;
	logic [1:0]  bl;
	logic [1:0]  lvl;
	logic [7:0]  bsel;

	always_comb begin
		rem  = sin.expire - clk_now;
		bl   = sin.bidx[9:8];
		cand = (sin.stat == htw_pkg::ST_PENDING) ||
			(sin.stat == htw_pkg::ST_WHEEL && rel[bl] &&
			 sin.bidx[7:0] == ridx[8*bl +: 8]);
		lvl = 2'd0;
		if (!rem[31] && rem > 32'd256) lvl = 2'd1;
		if (!rem[31] && rem > 32'd65536) lvl = 2'd2;
		if (!rem[31] && rem > 32'h0100_0000) lvl = 2'd3;
		bsel = sin.expire[8*lvl +: 8];
		sout = sin;
		fire = 1'b0;
		late = 1'b0;
		if (func == htw_pkg::FUNC_TICK) begin
			if (cand) begin
				if (!rem[31] && rem != 32'd0) begin
					sout.bidx  = {lvl, bsel};
					sout.stat  = htw_pkg::ST_WHEEL;
					sout.fresh = 1'b0;
				end else if (full) begin
					sout.stat = htw_pkg::ST_PENDING;
				end else begin
					fire = 1'b1;
					late = !sin.fresh && rem[31];
					if (sin.periodic) begin
						sout.expire = clk_now + {1'b0, sin.interval};
						sout.stat   = htw_pkg::ST_PENDING;
						sout.fresh  = 1'b1;
					end else begin
						sout.stat  = htw_pkg::ST_IDLE;
						sout.fresh = 1'b0;
					end
				end
			end
		end else if (sin.stat == htw_pkg::ST_WHEEL) begin
			// skip ahead
			if ($signed(rem) < $signed({1'b0, amount}))
				sout.expire = clk_now + {1'b0, amount};
			sout.stat  = htw_pkg::ST_PENDING;
			sout.fresh = 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: hdl/hierarchical_timer_wheel_top.sv
// ---------------------------------------------------------------------------
// hierarchical_timer_wheel_top: 32-slot, four-level timer wheel, one slot per RAM pass.
// Tick and nonzero skip sweep every slot: RAM read (S_WAIT), then update and write-back
// (S_UPD); each fired item passes S_OUT, held there while out.ready is low. Arm, cancel:
// one slot. A new item is taken only in S_IDLE. Reset clears the clock and sweeps the RAM
// to idle, during which no item is accepted.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hierarchical_timer_wheel_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	htw_in_if.sink     in,
	htw_out_if.source  out
);
	localparam int SlotW = $bits(htw_pkg::slot_t);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_UPD, S_OUT} state_t;
	state_t state_q;

	htw_pkg::in_t   req_q;
	logic [31:0]    clk_q;
	logic [4:0]     idx_q;
	logic [5:0]     nfire_q;
	logic [3:0]     rel_q;
	logic           any_q;
	logic           pend_q;
	htw_pkg::out_t  hold_q;
	logic           we;
	logic [4:0]     addr;
	htw_pkg::slot_t wdata, rdata, uout;
	logic           fire, late;
	logic [31:0]    ncl;
	logic [3:0]     nrel;
	logic [31:0]    rem;
	logic           shorter;

	htw_ram #(.Width(SlotW), .Depth(htw_pkg::TimerCount)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	htw_slot_unit u_unit (
		.func(req_q.func), .clk_now(clk_q), .amount(req_q.amount), .rel(rel_q),
		.ridx(clk_q), .full(nfire_q == 6'(htw_pkg::MaxResults)), .sin(rdata),
		.sout(uout), .fire(fire), .late(late)
	);

	always_comb begin
		ncl  = clk_q + 32'd1;
		nrel = 4'b0001;
		if (ncl[7:0] == 8'd0) nrel[1] = 1'b1;
		if (ncl[15:0] == 16'd0) nrel[2] = 1'b1;
		if (ncl[23:0] == 24'd0) nrel[3] = 1'b1;
		rem = rdata.expire - clk_q;
		shorter = $signed({1'b0, req_q.amount}) < $signed(rem);
	end

	always_comb begin
		we    = 1'b0;
		addr  = idx_q;
		wdata = uout;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			wdata = '0;
		end else if (state_q == S_UPD) begin
			if (req_q.func == htw_pkg::FUNC_ARM) begin
				we = 1'b1;
				wdata = rdata;
				wdata.expire   = clk_q + {1'b0, req_q.amount};
				wdata.periodic = req_q.repeat_req;
				wdata.interval = req_q.period;
				if (!(rdata.stat == htw_pkg::ST_PENDING || rdata.stat == htw_pkg::ST_WHEEL)
					|| shorter) begin
					wdata.stat  = htw_pkg::ST_PENDING;
					wdata.fresh = 1'b1;
				end
			end else if (req_q.func == htw_pkg::FUNC_CANCEL) begin
				we = 1'b1;
				wdata = rdata;
				wdata.stat  = htw_pkg::ST_IDLE;
				wdata.fresh = 1'b0;
			end else begin
				we = 1'b1;
			end
		end
	end

	assign in.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clk_q     <= '0;
			idx_q     <= '0;
			nfire_q   <= '0;
			rel_q     <= '0;
			any_q     <= 1'b0;
			pend_q    <= 1'b0;
			out.valid <= 1'b0;
			req_q     <= '0;
			hold_q    <= '0;
			out.data  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'(htw_pkg::TimerCount - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in.valid) begin
						req_q   <= in.data;
						nfire_q <= '0;
						any_q   <= 1'b0;
						pend_q  <= 1'b0;
						if (in.data.func == htw_pkg::FUNC_TICK) begin
							clk_q <= ncl;
							rel_q <= nrel;
							idx_q <= '0;
							state_q <= S_WAIT;
						end else if (in.data.func == htw_pkg::FUNC_SKIP) begin
							idx_q <= '0;
							if (in.data.amount != 31'd0) state_q <= S_WAIT;
						end else begin
							idx_q <= in.data.timer_id;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: state_q <= S_UPD;
				S_UPD: begin
					// hold each fired item; the held one goes out once the next is known
					if (fire) begin
						nfire_q <= nfire_q + 6'd1;
						hold_q  <= '{fired_id: idx_q, late: late, last: 1'b0};
					end
					if (req_q.func == htw_pkg::FUNC_ARM || req_q.func == htw_pkg::FUNC_CANCEL)
						state_q <= S_IDLE;
					else if (idx_q == 5'(htw_pkg::TimerCount - 1)) begin
						if (req_q.func == htw_pkg::FUNC_SKIP) begin
							clk_q   <= clk_q + {1'b0, req_q.amount};
							state_q <= S_IDLE;
						end else if (fire || pend_q) begin
							any_q     <= 1'b1;
							state_q   <= S_OUT;
							out.valid <= 1'b1;
							if (fire && pend_q) begin
								out.data <= hold_q;
							end else begin
								out.data <= '{fired_id: fire ? idx_q : hold_q.fired_id,
									late: fire ? late : hold_q.late, last: 1'b1};
								pend_q   <= 1'b0;
							end
						end else state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 5'd1;
						if (fire && pend_q) begin
							out.data  <= hold_q;
							out.valid <= 1'b1;
							state_q   <= S_OUT;
						end else begin
							if (fire) pend_q <= 1'b1;
							state_q <= S_WAIT;
						end
					end
				end
				S_OUT: begin
					if (out.ready || !out.valid) begin
						if (any_q && pend_q) begin
							out.data  <= '{fired_id: hold_q.fired_id, late: hold_q.late,
								last: 1'b1};
							out.valid <= 1'b1;
							pend_q    <= 1'b0;
						end else begin
							out.valid <= 1'b0;
							state_q   <= any_q ? S_IDLE : S_WAIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !in.ready,
		"ready while busy")
	`ASSERT_IMPL(a_out_only_tick, clk, arst_n, out.valid, req_q.func == htw_pkg::FUNC_TICK,
		"result from non-tick item")
	`ASSERT_IMPL(a_fire_cap, clk, arst_n, state_q == S_UPD,
		nfire_q <= 6'(htw_pkg::MaxResults), "too many results")
endmodule
`default_nettype wire

// File: dv/hierarchical_timer_wheel_top_tb.sv
// ---------------------------------------------------------------------------
// Timer wheel testbench
// Drives tick, arm, cancel and skip items into the timer wheel, predicts the
// expiry items of every tick from a local copy of the timer table, and checks
// each one in order. Both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_timer_wheel_top_tb;
	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	htw_in_if  in_ch();
	htw_out_if out_ch();

	hierarchical_timer_wheel_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	// predictor state
	logic [31:0]     now_ticks;
	logic [31:0]     exp_at   [htw_pkg::TimerCount];
	logic [9:0]      bucket   [htw_pkg::TimerCount];
	htw_pkg::stat_t  status   [htw_pkg::TimerCount];
	logic            fresh    [htw_pkg::TimerCount];
	logic            periodic [htw_pkg::TimerCount];
	logic [30:0]     interval [htw_pkg::TimerCount];

	htw_pkg::out_t expiry_q[$];
	int errors = 0;
	int items_sent = 0;
	int expiries_seen = 0;
	int idle_cycles = 0;
	int max_gap = 3;

	function automatic longint remaining(logic [31:0] a, logic [31:0] b);
		logic signed [31:0] d;
		d = a - b;
		return longint'(d);
	endfunction

	function automatic void file_slot(int i, longint rem);
		int lvl;
		lvl = 0;
		if (rem > (64'sd1 << htw_pkg::LevelBits)) lvl = 1;
		if (rem > (64'sd1 << (2 * htw_pkg::LevelBits))) lvl = 2;
		if (rem > (64'sd1 << (3 * htw_pkg::LevelBits))) lvl = 3;
		if (lvl > htw_pkg::WheelLevels - 1) lvl = htw_pkg::WheelLevels - 1;
		bucket[i] = {lvl[1:0], 8'(exp_at[i] >> (lvl * htw_pkg::LevelBits))};
		status[i] = htw_pkg::ST_WHEEL;
		fresh[i] = 1'b0;
	endfunction

	function automatic void wheel_reset();
		now_ticks = '0;
		for (int i = 0; i < htw_pkg::TimerCount; i++) begin
			exp_at[i] = '0; bucket[i] = '0; status[i] = htw_pkg::ST_IDLE;
			fresh[i] = 0; periodic[i] = 0; interval[i] = '0;
		end
	endfunction

	function automatic void run_tick();
		bit rel[4];
		logic [7:0] ridx[4];
		bit cand[htw_pkg::TimerCount];
		int n, bl, last_pos;
		longint rem;
		htw_pkg::out_t r;
		n = 0;
		last_pos = -1;
		for (int l = 0; l < 4; l++) begin rel[l] = 0; ridx[l] = '0; end
		now_ticks = now_ticks + 1;
		for (int l = 0; l < htw_pkg::WheelLevels; l++) begin
			rel[l] = 1;
			ridx[l] = 8'(now_ticks >> (l * htw_pkg::LevelBits));
			if (ridx[l] != 0) break;
		end
		for (int i = 0; i < htw_pkg::TimerCount; i++) begin
			bl = bucket[i][9:8];
			cand[i] = status[i] == htw_pkg::ST_PENDING ||
				(status[i] == htw_pkg::ST_WHEEL && rel[bl] && bucket[i][7:0] == ridx[bl]);
		end
		for (int i = 0; i < htw_pkg::TimerCount; i++) begin
			if (!cand[i]) continue;
			rem = remaining(exp_at[i], now_ticks);
			if (rem > 0) begin
				file_slot(i, rem);
				continue;
			end
			if (n >= htw_pkg::MaxResults) begin
				status[i] = htw_pkg::ST_PENDING;
				continue;
			end
			r.fired_id = 5'(i);
			r.late = !fresh[i] && rem < 0;
			r.last = 1'b0;
			expiry_q.push_back(r);
			last_pos = expiry_q.size() - 1;
			n++;
			if (periodic[i]) begin
				exp_at[i] = now_ticks + 32'(interval[i]);
				status[i] = htw_pkg::ST_PENDING;
				fresh[i] = 1'b1;
			end else begin
				status[i] = htw_pkg::ST_IDLE;
				fresh[i] = 1'b0;
			end
		end
		if (last_pos >= 0) expiry_q[last_pos].last = 1'b1;
	endfunction

	function automatic void predict_item(htw_pkg::in_t it);
		logic [31:0] old;
		int id;
		id = it.timer_id;
		case (htw_pkg::func_t'(it.func))
			htw_pkg::FUNC_TICK: run_tick();
			htw_pkg::FUNC_ARM: begin
				old = exp_at[id];
				exp_at[id] = now_ticks + 32'(it.amount);
				periodic[id] = it.repeat_req;
				interval[id] = it.period;
				if (status[id] == htw_pkg::ST_PENDING || status[id] == htw_pkg::ST_WHEEL) begin
					if (remaining(exp_at[id], now_ticks) < remaining(old, now_ticks)) begin
						status[id] = htw_pkg::ST_PENDING;
						fresh[id] = 1'b1;
					end
				end else begin
					status[id] = htw_pkg::ST_PENDING;
					fresh[id] = 1'b1;
				end
			end
			htw_pkg::FUNC_CANCEL: begin
				status[id] = htw_pkg::ST_IDLE;
				fresh[id] = 1'b0;
			end
			default: begin
				if (it.amount != 0) begin
					for (int i = 0; i < htw_pkg::TimerCount; i++) begin
						if (status[i] != htw_pkg::ST_WHEEL) continue;
						if (remaining(exp_at[i], now_ticks) < longint'(it.amount))
							exp_at[i] = now_ticks + 32'(it.amount);
						status[i] = htw_pkg::ST_PENDING;
						fresh[i] = 1'b0;
					end
					now_ticks = now_ticks + 32'(it.amount);
				end
			end
		endcase
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, max_gap);
	endfunction

	// valid stays high after an accept only when the next item follows at once
	task automatic send_item(htw_pkg::in_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_op(htw_pkg::func_t f, int id, logic [30:0] amt, logic rep,
			logic [30:0] per);
		htw_pkg::in_t it;
		it.func = f; it.timer_id = 5'(id); it.amount = amt;
		it.repeat_req = rep; it.period = per;
		send_item(it);
	endtask

	task automatic tick_n(int n);
		for (int k = 0; k < n; k++) send_op(htw_pkg::FUNC_TICK, $urandom_range(0, 31),
			31'($urandom), 1'($urandom), 31'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expiry_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// result side: random stalls, ordered compare
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				expiries_seen++;
				if (expiry_q.size() == 0) begin
					$display("%0t: unexpected item id=%0d late=%0d last=%0d", $time,
						out_ch.data.fired_id, out_ch.data.late, out_ch.data.last);
					errors++;
				end else begin
					htw_pkg::out_t e;
					e = expiry_q.pop_front();
					if (e.fired_id !== out_ch.data.fired_id) begin
						$display("%0t: fired_id expected %0d actual %0d", $time,
							e.fired_id, out_ch.data.fired_id);
						errors++;
					end
					if (e.late !== out_ch.data.late) begin
						$display("%0t: late expected %0d actual %0d (id %0d)", $time,
							e.late, out_ch.data.late, e.fired_id);
						errors++;
					end
					if (e.last !== out_ch.data.last) begin
						$display("%0t: last expected %0d actual %0d (id %0d)", $time,
							e.last, out_ch.data.last, e.fired_id);
						errors++;
					end
				end
			end
			out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 2) != 0);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_op(htw_pkg::FUNC_ARM, 0, 31'd0, 1'b0, 31'd0);           // zero delay
		send_op(htw_pkg::FUNC_ARM, 31, 31'd1, 1'b0, 31'h7fffffff);
		send_op(htw_pkg::FUNC_ARM, 5, 31'd256, 1'b0, 31'd0);          // level edges
		send_op(htw_pkg::FUNC_ARM, 6, 31'd257, 1'b0, 31'd0);
		send_op(htw_pkg::FUNC_ARM, 7, 31'd65537, 1'b0, 31'd0);
		send_op(htw_pkg::FUNC_ARM, 8, 31'h7fffffff, 1'b1, 31'd3);
		send_op(htw_pkg::FUNC_ARM, 9, 31'd2, 1'b1, 31'd2);             // periodic
		tick_n(4);
		send_op(htw_pkg::FUNC_ARM, 5, 31'd400, 1'b0, 31'd0);  // longer re-arm stays filed
		send_op(htw_pkg::FUNC_ARM, 6, 31'd1, 1'b0, 31'd0);            // shorter re-arm
		send_op(htw_pkg::FUNC_CANCEL, 9, 31'd0, 1'b0, 31'd0);
		send_op(htw_pkg::FUNC_SKIP, 0, 31'd0, 1'b0, 31'd0);           // skip nothing
		send_op(htw_pkg::FUNC_SKIP, 0, 31'd300, 1'b0, 31'd0);         // overdue after skip
		tick_n(2);
		for (int i = 0; i < htw_pkg::TimerCount; i++)                 // all fire on one tick
			send_op(htw_pkg::FUNC_ARM, i, 31'd1, 1'b0, 31'd0);
		tick_n(2);
		send_op(htw_pkg::FUNC_SKIP, 0, 31'h7fffffff, 1'b0, 31'd0);
		tick_n(1);
		drain();
	endtask

	task automatic test_wheel_random(int n_items);
		int pick;
		logic [30:0] amt;
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: amt = 31'($urandom_range(0, 8));
				1: amt = 31'($urandom_range(200, 300));
				2: amt = 31'($urandom_range(0, 70000));
				default: amt = 31'($urandom);
			endcase
			if (pick < 55) tick_n(1);
			else if (pick < 82) send_op(htw_pkg::FUNC_ARM, $urandom_range(0, 31),
				($urandom_range(0, 1)) ? 31'($urandom_range(0, 20)) : amt,
				1'($urandom), ($urandom_range(0, 1)) ? 31'($urandom_range(0, 6)) :
				31'($urandom));
			else if (pick < 92) send_op(htw_pkg::FUNC_CANCEL, $urandom_range(0, 31), amt,
				1'($urandom), 31'($urandom));
			else send_op(htw_pkg::FUNC_SKIP, $urandom_range(0, 31),
				($urandom_range(0, 2) == 0) ? amt : 31'($urandom_range(0, 300)),
				1'($urandom), 31'($urandom));
		end
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		wheel_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		max_gap = 0;
		test_wheel_random(120);
		max_gap = 6;
		test_wheel_random(256);
		$display("Sent %0d items (ticks, arms, cancels, skips); checked %0d expiries.",
			items_sent, expiries_seen);
		if (errors == 0 && expiry_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// File: hierarchical_timer_wheel_top.f
+incdir+hdl
hdl/htw_pkg.sv
hdl/htw_if.sv
hdl/htw_ram.sv
hdl/htw_slot_unit.sv
hdl/hierarchical_timer_wheel_top.sv
dv/hierarchical_timer_wheel_top_tb.sv
